// ===== rtl/core/rvmt_pkg.sv =====
// shared constants, codes and types of the rssi motion tracker
`default_nettype none

package rvmt_pkg;

    localparam int unsigned PEER_SLOTS_DEF   = 16;
    localparam int unsigned WINDOW_DEPTH_DEF = 32;

    localparam int unsigned OP_W       = 2;
    localparam int unsigned MAC_W      = 48;
    localparam int unsigned RSSI_W     = 8;
    localparam int unsigned STATUS_W   = 2;
    localparam int unsigned SLOT_OUT_W = 4;
    localparam int unsigned VAR_W      = 18;
    localparam int unsigned HELD_W     = 6;
    localparam int unsigned PEERS_W    = 5;
    localparam int unsigned THR_W      = 18;

    localparam logic [THR_W-1:0] THR_RESET = THR_W'(80);

    localparam logic [OP_W-1:0] OP_SAMPLE   = 2'd0;
    localparam logic [OP_W-1:0] OP_PRESENCE = 2'd1;
    localparam logic [OP_W-1:0] OP_SWEEP    = 2'd2;
    localparam logic [OP_W-1:0] OP_RESERVED = 2'd3;

    localparam logic [STATUS_W-1:0] STAT_RECORDED = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_IGNORED  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL     = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_DONE     = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SEARCH,
        S_WREAD,
        S_UPDATE,
        S_LREAD,
        S_MUL,
        S_SUB,
        S_DIV,
        S_FIN,
        S_SWEEP,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic [SLOT_OUT_W-1:0]    slot;
        logic signed [RSSI_W-1:0] last_rssi;
        logic [VAR_W-1:0]         variance;
        logic                     motion;
        logic [HELD_W-1:0]        samples_held;
        logic [PEERS_W-1:0]       active_peers;
        logic [PEERS_W-1:0]       expired_peers;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/core/rvmt_chan_if.sv =====
// valid/ready channel interfaces for report beats and result beats
`default_nettype none

interface rvmt_in_if import rvmt_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [OP_W-1:0]          op;
    logic [MAC_W-1:0]         peer_mac;
    logic signed [RSSI_W-1:0] rssi_dbm;
    logic                     one_hop;

    modport source (output valid, op, peer_mac, rssi_dbm, one_hop, input ready);
    modport sink   (input valid, op, peer_mac, rssi_dbm, one_hop, output ready);
endinterface

interface rvmt_out_if import rvmt_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [STATUS_W-1:0]      status;
    logic [SLOT_OUT_W-1:0]    slot;
    logic signed [RSSI_W-1:0] last_rssi;
    logic [VAR_W-1:0]         variance;
    logic                     motion;
    logic [HELD_W-1:0]        samples_held;
    logic [PEERS_W-1:0]       active_peers;
    logic [PEERS_W-1:0]       expired_peers;

    modport source (output valid, status, slot, last_rssi, variance, motion, samples_held,
                    active_peers, expired_peers, input ready);
    modport sink   (input valid, status, slot, last_rssi, variance, motion, samples_held,
                    active_peers, expired_peers, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/rssi_variance_motion_tracker.sv =====
// top level of the per-peer rssi variance motion tracker
//
// channels: i_in takes report beats (op, peer_mac, rssi_dbm, one_hop),
// o_out gives exactly one result beat per report; both are valid/ready.
// i_cfg_we/i_cfg_wdata write the motion limit; the user must write it only
// while the block is idle, which the block itself does not enforce. one
// report is worked on at a time; i_in.ready is high only in idle. sample
// and presence reports walk the peer tag ram one slot a cycle (pipelined,
// stopping early on a hit); a sample then reads, updates and writes back
// the window ram; the statistics take a multiply step, a subtract step and
// an 18-step restoring divider for the variance. the end-of-sweep op walks
// the slot flags one a cycle. ignored reports go straight from idle to the
// done state. the result sits in an output register, so a new report is
// taken while a finished result still waits; if the receiver stalls, the
// next result is held in the last state until the output register frees
// up. synchronous reset empties the table, clears all marks and the
// occupancy count and sets the threshold to 80; the tag and window rams
// need no clearing since only written entries are ever used.
`default_nettype none

module rssi_variance_motion_tracker import rvmt_pkg::*; #(
    parameter int unsigned PEER_SLOTS   = PEER_SLOTS_DEF,
    parameter int unsigned WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    rvmt_in_if.sink               i_in,
    rvmt_out_if.source            o_out,
    input  wire logic             i_cfg_we,
    input  wire logic [THR_W-1:0] i_cfg_wdata
);

    // widths
    localparam int unsigned SW    = (PEER_SLOTS > 1) ? $clog2(PEER_SLOTS) : 1;
    localparam int unsigned PW    = $clog2(WINDOW_DEPTH);
    localparam int unsigned CW    = $clog2(WINDOW_DEPTH + 1);
    localparam int unsigned SUMW  = PW + 9;
    localparam int unsigned SQW   = PW + 15;
    localparam int unsigned MAGW  = PW + 8;
    localparam int unsigned NUMW  = CW + SQW;
    localparam int unsigned DW    = NUMW + 4;
    localparam int unsigned DENW  = 2 * CW;
    localparam int unsigned CMPW  = (DW > DENW + VAR_W - 1) ? DW : DENW + VAR_W - 1;
    localparam int unsigned STEPW = $clog2(VAR_W);
    localparam int unsigned CNTW  = $clog2(PEER_SLOTS + 1);

    localparam logic [SW-1:0] LAST_SLOT = SW'(PEER_SLOTS - 1);
    localparam logic [PW-1:0] LAST_POS  = PW'(WINDOW_DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(WINDOW_DEPTH);

    // control state
    t_state              r_state, n_state;
    logic                r_out_valid;
    logic [PEER_SLOTS-1:0] r_valid;
    logic [PEER_SLOTS-1:0] r_seen;
    logic [CNTW-1:0]     r_occ;
    logic [THR_W-1:0]    r_thr;

    // current report
    logic [OP_W-1:0]          r_op;
    logic [MAC_W-1:0]         r_mac;
    logic signed [RSSI_W-1:0] r_rssi;

    // search walk
    logic [SW-1:0] r_idx;
    logic [SW-1:0] r_chk_idx;
    logic          r_chk_v;
    logic          r_issue_done;
    logic          r_free_v;
    logic [SW-1:0] r_free_idx;
    logic [SW-1:0] r_slot;

    // per-slot window bookkeeping
    logic [PW-1:0]          r_wp   [PEER_SLOTS];
    logic [CW-1:0]          r_fill [PEER_SLOTS];
    logic signed [SUMW-1:0] r_sum  [PEER_SLOTS];
    logic [SQW-1:0]         r_sq   [PEER_SLOTS];

    // statistics datapath
    logic [CW-1:0]          r_n;
    logic signed [SUMW-1:0] r_s1;
    logic [SQW-1:0]         r_s2;
    logic [NUMW-1:0]        r_p1;
    logic [2*MAGW-1:0]      r_p2;
    logic [DENW-1:0]        r_den;
    logic [CMPW-1:0]        r_rem;
    logic [CMPW-1:0]        r_dsh;
    logic [VAR_W-1:0]       r_q;
    logic [STEPW-1:0]       r_step;
    logic [CNTW-1:0]        r_expired;
    t_result                r_res;
    t_result                r_out;

    // ram ports
    logic [MAC_W-1:0]  tag_rd;
    logic              tag_we;
    logic [RSSI_W-1:0] win_rd;
    logic              win_we;
    logic [PW-1:0]     win_rpos;

    // decode
    logic in_accept;
    logic [STATUS_W-1:0] in_status;
    logic hit;
    logic last_chk;
    logic cur_free;
    logic free_v_now;
    logic [SW-1:0] free_idx_now;
    logic alloc;
    logic out_load;

    assign in_accept    = i_in.valid && i_in.ready;
    // status known at accept time; table full is found later in the search
    assign in_status    = (i_in.op == OP_SAMPLE && i_in.one_hop) ? STAT_RECORDED :
                          (i_in.op == OP_PRESENCE || i_in.op == OP_SWEEP) ? STAT_DONE :
                          STAT_IGNORED;
    assign hit          = r_chk_v && r_valid[r_chk_idx] && (tag_rd == r_mac);
    assign last_chk     = r_chk_v && (r_chk_idx == LAST_SLOT);
    assign cur_free     = r_chk_v && !r_valid[r_chk_idx];
    assign free_v_now   = r_free_v || cur_free;
    assign free_idx_now = r_free_v ? r_free_idx : r_chk_idx;
    // miss on a sample report with a free slot: take the lowest free one
    assign alloc        = (r_state == S_SEARCH) && !hit && last_chk
                          && (r_op == OP_SAMPLE) && free_v_now;
    assign out_load     = (r_state == S_DONE) && (!r_out_valid || o_out.ready);

    // window update arithmetic
    logic [PW-1:0]          cur_wp;
    logic [CW-1:0]          cur_fill;
    logic                   win_full;
    logic signed [15:0]     old_sq_s;
    logic signed [15:0]     new_sq_s;
    logic signed [SUMW-1:0] sum_n;
    logic [SQW-1:0]         sq_n;
    logic [PW-1:0]          wp_n;
    logic [CW-1:0]          fill_n;
    logic [MAGW-1:0]        mag;
    logic                   div_ge;
    logic [DW-1:0]          num16;

    assign cur_wp   = r_wp[r_slot];
    assign cur_fill = r_fill[r_slot];
    assign win_full = (cur_fill >= FULL_CNT);
    assign old_sq_s = $signed(win_rd) * $signed(win_rd);
    assign new_sq_s = r_rssi * r_rssi;
    assign sum_n    = r_sum[r_slot] - (win_full ? SUMW'($signed(win_rd)) : SUMW'(0))
                      + SUMW'(r_rssi);
    assign sq_n     = r_sq[r_slot] - (win_full ? SQW'($unsigned(old_sq_s)) : SQW'(0))
                      + SQW'($unsigned(new_sq_s));
    assign wp_n     = (cur_wp == LAST_POS) ? '0 : cur_wp + PW'(1);
    assign fill_n   = win_full ? cur_fill : cur_fill + CW'(1);
    assign mag      = (r_s1 < 0) ? MAGW'(-r_s1) : MAGW'(r_s1);
    assign div_ge   = (r_rem >= r_dsh);
    assign num16    = {r_p1 - NUMW'(r_p2), 4'b0000};
    // newest entry sits just behind the write pointer
    assign win_rpos = (r_state == S_LREAD) ? ((cur_wp == '0) ? LAST_POS : cur_wp - PW'(1))
                                           : cur_wp;
    assign tag_we   = alloc;
    assign win_we   = (r_state == S_UPDATE);

    rvmt_ram #(
        .WIDTH (MAC_W),
        .DEPTH (1 << SW)
    ) u_tag_ram (
        .i_clk   (i_clk),
        .i_we    (tag_we),
        .i_waddr (free_idx_now),
        .i_wdata (r_mac),
        .i_raddr (r_idx),
        .o_rdata (tag_rd)
    );

    rvmt_ram #(
        .WIDTH (RSSI_W),
        .DEPTH ((1 << SW) << PW)
    ) u_win_ram (
        .i_clk   (i_clk),
        .i_we    (win_we),
        .i_waddr ({r_slot, cur_wp}),
        .i_wdata (r_rssi),
        .i_raddr ({r_slot, win_rpos}),
        .o_rdata (win_rd)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    if ((i_in.op == OP_SAMPLE && i_in.one_hop) || i_in.op == OP_PRESENCE) begin
                        n_state = S_SEARCH;
                    end else if (i_in.op == OP_SWEEP) begin
                        n_state = S_SWEEP;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_SEARCH: begin
                priority if (hit) begin
                    n_state = (r_op == OP_SAMPLE) ? S_WREAD : S_LREAD;
                end else if (last_chk) begin
                    n_state = alloc ? S_WREAD : S_DONE;
                end
            end
            S_WREAD:  n_state = S_UPDATE;
            S_UPDATE: n_state = S_MUL;
            S_LREAD:  n_state = S_MUL;
            S_MUL:    n_state = S_SUB;
            S_SUB:    n_state = (r_n < CW'(2)) ? S_DONE : S_DIV;
            S_DIV:    n_state = (r_step == '0) ? S_FIN : S_DIV;
            S_FIN:    n_state = S_DONE;
            S_SWEEP:  n_state = (r_idx == LAST_SLOT) ? S_DONE : S_SWEEP;
            S_DONE:   n_state = out_load ? S_IDLE : S_DONE;
            default:  n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_valid     <= '0;
            r_seen      <= '0;
            r_occ       <= '0;
            r_thr       <= THR_RESET;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_thr <= i_cfg_wdata;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (alloc) begin
                r_valid[free_idx_now] <= 1'b1;
                r_seen[free_idx_now]  <= 1'b0;
                r_occ                 <= r_occ + CNTW'(1);
            end
            if (r_state == S_SEARCH && hit && r_op == OP_PRESENCE) begin
                r_seen[r_chk_idx] <= 1'b1;
            end
            // sweep: drop unmarked peers, then clear every mark
            if (r_state == S_SWEEP) begin
                if (r_valid[r_idx] && !r_seen[r_idx]) begin
                    r_valid[r_idx] <= 1'b0;
                    r_occ          <= r_occ - CNTW'(1);
                end
                r_seen[r_idx] <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    r_op         <= i_in.op;
                    r_mac        <= i_in.peer_mac;
                    r_rssi       <= i_in.rssi_dbm;
                    r_idx        <= '0;
                    r_chk_v      <= 1'b0;
                    r_issue_done <= 1'b0;
                    r_free_v     <= 1'b0;
                    r_expired    <= '0;
                    r_res        <= '{status: in_status, default: '0};
                end
            end
            S_SEARCH: begin
                // pipelined tag walk: issue one slot, check the one before
                if (cur_free && !r_free_v) begin
                    r_free_v   <= 1'b1;
                    r_free_idx <= r_chk_idx;
                end
                r_chk_v   <= !r_issue_done;
                r_chk_idx <= r_idx;
                if (r_idx == LAST_SLOT) begin
                    r_issue_done <= 1'b1;
                end else begin
                    r_idx <= r_idx + SW'(1);
                end
                if (hit) begin
                    r_slot <= r_chk_idx;
                end else if (alloc) begin
                    r_slot               <= free_idx_now;
                    r_wp[free_idx_now]   <= '0;
                    r_fill[free_idx_now] <= '0;
                    r_sum[free_idx_now]  <= '0;
                    r_sq[free_idx_now]   <= '0;
                end else if (last_chk && r_op == OP_SAMPLE) begin
                    r_res.status <= STAT_FULL;
                end
            end
            S_WREAD: begin
            end
            S_UPDATE: begin
                r_sum[r_slot]  <= sum_n;
                r_sq[r_slot]   <= sq_n;
                r_wp[r_slot]   <= wp_n;
                r_fill[r_slot] <= fill_n;
                r_n            <= fill_n;
                r_s1           <= sum_n;
                r_s2           <= sq_n;
            end
            S_LREAD: begin
                r_n  <= cur_fill;
                r_s1 <= r_sum[r_slot];
                r_s2 <= r_sq[r_slot];
            end
            S_MUL: begin
                r_p1  <= r_n * r_s2;
                r_p2  <= mag * mag;
                r_den <= r_n * r_n;
                r_res.slot         <= SLOT_OUT_W'(r_slot);
                r_res.samples_held <= HELD_W'(r_n);
                if (r_op == OP_SAMPLE) begin
                    r_res.last_rssi <= r_rssi;
                end else begin
                    r_res.last_rssi <= (r_n == '0) ? '0 : $signed(win_rd);
                end
            end
            S_SUB: begin
                r_rem  <= CMPW'(num16);
                r_dsh  <= CMPW'(r_den) << (VAR_W - 1);
                r_q    <= '0;
                r_step <= STEPW'(VAR_W - 1);
            end
            S_DIV: begin
                // restoring division, one quotient bit a cycle, msb first
                if (div_ge) begin
                    r_rem <= r_rem - r_dsh;
                end
                r_q    <= {r_q[VAR_W-2:0], div_ge};
                r_dsh  <= r_dsh >> 1;
                r_step <= r_step - STEPW'(1);
            end
            S_FIN: begin
                // exact compare: floor above threshold, or equal with remainder
                r_res.variance <= r_q;
                r_res.motion   <= (r_q > r_thr) || ((r_q == r_thr) && (r_rem != '0));
            end
            S_SWEEP: begin
                if (r_valid[r_idx] && !r_seen[r_idx]) begin
                    r_expired <= r_expired + CNTW'(1);
                end
                if (r_idx != LAST_SLOT) begin
                    r_idx <= r_idx + SW'(1);
                end
            end
            S_DONE: begin
                if (out_load) begin
                    r_out <= '{status:        r_res.status,
                               slot:          r_res.slot,
                               last_rssi:     r_res.last_rssi,
                               variance:      r_res.variance,
                               motion:        r_res.motion,
                               samples_held:  r_res.samples_held,
                               active_peers:  PEERS_W'(r_occ),
                               expired_peers: PEERS_W'(r_expired)};
                end
            end
            default: begin
            end
        endcase
    end

    assign i_in.ready          = (r_state == S_IDLE);
    assign o_out.valid         = r_out_valid;
    assign o_out.status        = r_out.status;
    assign o_out.slot          = r_out.slot;
    assign o_out.last_rssi     = r_out.last_rssi;
    assign o_out.variance      = r_out.variance;
    assign o_out.motion        = r_out.motion;
    assign o_out.samples_held  = r_out.samples_held;
    assign o_out.active_peers  = r_out.active_peers;
    assign o_out.expired_peers = r_out.expired_peers;

endmodule

`default_nettype wire

// ===== rtl/core/rvmt_ram.sv =====
// generic single write, single read ram with registered read data
`default_nettype none

module rvmt_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/core/rvmt_checker.sv =====
// port-level assertions for the rssi motion tracker, bound to the top level
`default_nettype none

module rvmt_checker import rvmt_pkg::*; (
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  i_out_valid,
    input wire logic                  i_out_ready,
    input wire logic [STATUS_W-1:0]   i_status,
    input wire logic [SLOT_OUT_W-1:0] i_slot,
    input wire logic [VAR_W-1:0]      i_variance,
    input wire logic                  i_motion,
    input wire logic [HELD_W-1:0]     i_samples_held,
    input wire logic [PEERS_W-1:0]    i_expired_peers
);

    // a waiting result beat stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result beat dropped while stalled");

    // ignored and table-full beats carry no peer statistics
    a_empty_stats: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status == STAT_IGNORED || i_status == STAT_FULL)
        |-> (i_slot == '0) && (i_variance == '0) && !i_motion && (i_samples_held == '0))
        else $error("statistics on a beat that names no peer");

    // variance and motion need at least two samples
    a_var_samples: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_motion || i_variance != '0) |-> (i_samples_held >= HELD_W'(2)))
        else $error("variance reported on fewer than two samples");

    // only sweep beats report expired peers
    a_expired_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_expired_peers != '0)
        |-> (i_status == STAT_DONE) && (i_slot == '0) && (i_samples_held == '0))
        else $error("expired peers on a non-sweep beat");

endmodule

bind rssi_variance_motion_tracker rvmt_checker u_rvmt_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_status        (o_out.status),
    .i_slot          (o_out.slot),
    .i_variance      (o_out.variance),
    .i_motion        (o_out.motion),
    .i_samples_held  (o_out.samples_held),
    .i_expired_peers (o_out.expired_peers)
);

`default_nettype wire

// ===== tb/rvmt_tb_checker.sv =====
// result checker for the rssi motion tracker: models the peer table and compares result beats
`default_nettype none

module rvmt_tb_checker import rvmt_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    input  wire logic             i_in_ready,
    input  wire logic [OP_W-1:0]  i_op,
    input  wire logic [MAC_W-1:0] i_mac,
    input  wire logic [7:0]       i_rssi,
    input  wire logic             i_direct,
    input  wire logic             i_out_valid,
    input  wire logic             i_out_ready,
    input  wire t_result          i_result,
    input  wire logic             i_cfg_we,
    input  wire logic [THR_W-1:0] i_cfg_wdata,
    output int                    o_errors,
    output int                    o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NSLOT = 16;
    localparam int DEPTH = 32;

    logic [MAC_W-1:0]  tag_q [NSLOT];
    bit                used_q [NSLOT];
    bit                mark_q [NSLOT];
    logic signed [7:0] win_q [NSLOT][DEPTH];
    int                wptr_q [NSLOT];
    int                fill_q [NSLOT];
    longint            sum_q [NSLOT];
    longint            sumsq_q [NSLOT];
    int                occupied;
    logic [THR_W-1:0]  threshold;
    t_result           expected_q [$];

    function automatic void fill_stats(int s, ref t_result r);
        longint unsigned num, den, v;
        int n;
        n = fill_q[s];
        r.slot = SLOT_OUT_W'(s);
        r.last_rssi = n ? win_q[s][(wptr_q[s] + DEPTH - 1) % DEPTH] : '0;
        r.samples_held = HELD_W'(n);
        if (n >= 2) begin
            num = longint'(n) * sumsq_q[s] - sum_q[s] * sum_q[s];
            den = longint'(n) * n;
            v = (num * 16) / den;
            r.motion = (num * 16) > longint'(threshold) * den;
            r.variance = (v > 262143) ? VAR_W'(262143) : VAR_W'(v);
        end
    endfunction

    // one report beat in, one expected result out
    function automatic t_result track_report(logic [OP_W-1:0] op, logic [MAC_W-1:0] mac,
                                             logic signed [7:0] rssi, logic direct);
        t_result r;
        int s, f, expired;
        r = '0;
        s = -1;
        expired = 0;
        if (op inside {OP_SAMPLE, OP_PRESENCE})
            for (int k = NSLOT - 1; k >= 0; k--)
                if (used_q[k] && tag_q[k] == mac) s = k;
        if (op == OP_SAMPLE && direct) begin
            if (s < 0) begin
                f = -1;
                for (int k = NSLOT - 1; k >= 0; k--) if (!used_q[k]) f = k;
                if (f >= 0) begin
                    s = f;
                    used_q[s] = 1; mark_q[s] = 0; tag_q[s] = mac;
                    wptr_q[s] = 0; fill_q[s] = 0; sum_q[s] = 0; sumsq_q[s] = 0;
                    occupied++;
                end
            end
            if (s < 0) r.status = STAT_FULL;
            else begin
                // full window: drop the oldest sample from the running sums
                if (fill_q[s] >= DEPTH) begin
                    sum_q[s] -= win_q[s][wptr_q[s]];
                    sumsq_q[s] -= win_q[s][wptr_q[s]] * win_q[s][wptr_q[s]];
                end else fill_q[s]++;
                win_q[s][wptr_q[s]] = rssi;
                sum_q[s] += rssi;
                sumsq_q[s] += rssi * rssi;
                wptr_q[s] = (wptr_q[s] + 1) % DEPTH;
                r.status = STAT_RECORDED;
                fill_stats(s, r);
            end
        end else if (op == OP_PRESENCE) begin
            r.status = STAT_DONE;
            if (s >= 0) begin
                mark_q[s] = 1;
                fill_stats(s, r);
            end
        end else if (op == OP_SWEEP) begin
            r.status = STAT_DONE;
            for (int k = 0; k < NSLOT; k++) begin
                if (used_q[k] && !mark_q[k]) begin
                    used_q[k] = 0;
                    expired++;
                    occupied--;
                end
                mark_q[k] = 0;
            end
        end else r.status = STAT_IGNORED;
        r.active_peers = PEERS_W'(occupied);
        r.expired_peers = PEERS_W'(expired);
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_result exp_r;
        if (!i_rst_n) begin
            for (int k = 0; k < NSLOT; k++) begin
                used_q[k] = 0; mark_q[k] = 0; wptr_q[k] = 0;
                fill_q[k] = 0; sum_q[k] = 0; sumsq_q[k] = 0;
            end
            occupied = 0;
            threshold = THR_RESET;
            expected_q.delete();
            o_errors = 0;
            o_pending = 0;
        end else begin
            if (i_cfg_we) threshold = i_cfg_wdata;
            if (i_out_valid && i_out_ready) begin
                if (expected_q.size() == 0) begin
                    $display("%0t: result beat with nothing expected, got %p", $time, i_result);
                    o_errors++;
                end else begin
                    exp_r = expected_q.pop_front();
                    if (exp_r !== i_result) begin
                        $display("%0t: result mismatch, expected %p, actual %p",
                                 $time, exp_r, i_result);
                        o_errors++;
                    end
                end
            end
            if (i_in_valid && i_in_ready)
                expected_q.push_back(track_report(i_op, i_mac, i_rssi, i_direct));
            o_pending = expected_q.size();
        end
    end
endmodule

`default_nettype wire

// ===== tb/tb_rssi_variance_motion_tracker.sv =====
// testbench top: report stimulus, threshold phases and verdict for the motion tracker
`default_nettype none

module tb_rssi_variance_motion_tracker;
    import rvmt_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 600000;

    logic             i_clk = 0;
    logic             i_rst_n = 0;
    logic             i_cfg_we = 0;
    logic [THR_W-1:0] i_cfg_wdata = '0;
    int               errors, pending, cycles = 0;
    int               sent = 0, n_samples = 0, n_presence = 0, n_sweeps = 0;
    logic [MAC_W-1:0] peer_pool [24];

    rvmt_in_if  in_ch();
    rvmt_out_if out_ch();
    t_result    result_beat;

    rssi_variance_motion_tracker uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch.sink), .o_out(out_ch.source),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata)
    );

    assign result_beat = '{out_ch.status, out_ch.slot, out_ch.last_rssi, out_ch.variance,
                           out_ch.motion, out_ch.samples_held, out_ch.active_peers,
                           out_ch.expired_peers};

    rvmt_tb_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_ch.valid), .i_in_ready(in_ch.ready), .i_op(in_ch.op),
        .i_mac(in_ch.peer_mac), .i_rssi(in_ch.rssi_dbm), .i_direct(in_ch.one_hop),
        .i_out_valid(out_ch.valid), .i_out_ready(out_ch.ready), .i_result(result_beat),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .o_errors(errors), .o_pending(pending)
    );

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    // watchdog on the whole run
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // receiver stall pattern: calm stretches, light stalls and heavy stalls
    initial begin
        int mode;
        out_ch.ready = 1;
        forever begin
            mode = $urandom_range(0, 2);
            repeat ($urandom_range(20, 200)) begin
                @(negedge i_clk);
                case (mode)
                    0: out_ch.ready <= 1;
                    1: out_ch.ready <= ($urandom_range(0, 3) != 0);
                    default: out_ch.ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // one report beat, held until accepted; caller is at a falling edge
    task automatic send_report(logic [OP_W-1:0] op, logic [MAC_W-1:0] mac,
                               logic [7:0] rssi, logic direct);
        in_ch.valid <= 1;
        in_ch.op <= op;
        in_ch.peer_mac <= mac;
        in_ch.rssi_dbm <= rssi;
        in_ch.one_hop <= direct;
        do @(posedge i_clk); while (!in_ch.ready);
        @(negedge i_clk);
        sent++;
        if (op == OP_SAMPLE) n_samples++;
        else if (op == OP_PRESENCE) n_presence++;
        else if (op == OP_SWEEP) n_sweeps++;
    endtask

    task automatic idle_input(int n);
        in_ch.valid <= 0;
        repeat (n) @(negedge i_clk);
    endtask

    // drain every result, let the tracker settle, then write the threshold
    task automatic set_threshold(logic [THR_W-1:0] value);
        idle_input(1);
        while (pending != 0) @(negedge i_clk);
        repeat (60) @(negedge i_clk);
        i_cfg_we <= 1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we <= 0;
    endtask

    // random report biased toward a small pool of peers so windows fill and wrap
    task automatic random_report();
        int pick;
        logic [MAC_W-1:0] mac;
        pick = $urandom_range(0, 99);
        mac = ($urandom_range(0, 9) == 0) ? MAC_W'({$urandom, $urandom})
                                          : peer_pool[$urandom_range(0, 23)];
        if (pick < 70)
            send_report(OP_SAMPLE, mac, ($urandom_range(0, 1) ? 8'($urandom)
                        : 8'($urandom_range(0, 40) - 80)), $urandom_range(0, 9) != 0);
        else if (pick < 88) send_report(OP_PRESENCE, mac, 8'($urandom), 1'($urandom));
        else if (pick < 96) send_report(OP_SWEEP, mac, 8'($urandom), 1'($urandom));
        else send_report(OP_RESERVED, mac, 8'($urandom), 1'($urandom));
    endtask

    initial begin
        logic [THR_W-1:0] thresholds [4];
        in_ch.valid = 0;
        in_ch.op = OP_SAMPLE;
        in_ch.peer_mac = '0;
        in_ch.rssi_dbm = '0;
        in_ch.one_hop = 0;
        thresholds = '{THR_W'(0), THR_W'(262143), THR_W'(500), THR_W'(80)};
        for (int k = 0; k < 24; k++) peer_pool[k] = MAC_W'({$urandom, $urandom});
        peer_pool[0] = '0;
        peer_pool[1] = '1;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);

        // directed: extremes, every op, indirect, unknown op, presence of an untracked peer
        send_report(OP_SAMPLE, peer_pool[0], 8'h80, 1);
        send_report(OP_SAMPLE, peer_pool[0], 8'h7f, 1);
        send_report(OP_SAMPLE, peer_pool[1], 8'h00, 1);
        send_report(OP_SAMPLE, peer_pool[1], 8'hff, 0);
        send_report(OP_PRESENCE, 48'h5555_aaaa_5555, 8'h00, 0);
        send_report(OP_PRESENCE, peer_pool[0], 8'h00, 1);
        send_report(OP_RESERVED, peer_pool[1], 8'h55, 1);
        send_report(OP_SWEEP, '0, 8'h00, 0);
        send_report(OP_SWEEP, '0, 8'h00, 0);
        // fill the table past capacity, then expire everything
        for (int k = 0; k < 17; k++) send_report(OP_SAMPLE, peer_pool[k + 2], 8'($urandom), 1);
        send_report(OP_SWEEP, '0, 8'h00, 1);

        // random phases across several thresholds, bursts and gaps from the sender
        foreach (thresholds[p]) begin
            set_threshold(thresholds[p]);
            repeat (325) begin
                if ($urandom_range(0, 7) == 0) idle_input($urandom_range(1, 40));
                random_report();
            end
            // let every result come back once per phase before sending more
            idle_input(1);
            while (pending != 0) @(negedge i_clk);
        end

        idle_input(1);
        while (pending != 0) @(negedge i_clk);
        repeat (100) @(posedge i_clk);
        $display("sent %0d reports: %0d samples, %0d presence, %0d sweeps", sent, n_samples,
                 n_presence, n_sweeps);
        $display("thresholds covered 0, 262143, 500 and 80 with wrapped and full tables");
        if (errors == 0) $display("No mismatches found");
        else $display("Mismatches found");
        $finish;
    end
endmodule

`default_nettype wire
